[sv/assert_macros.svh]
// assertion macros used by the bfs edge labeler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMP(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
        else $error("same-cycle check failed");
`define CHK_NXT(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
        else $error("next-cycle check failed");
`else
`define CHK_IMP(lbl, ck, rn, ant, con)
`define CHK_NXT(lbl, ck, rn, ant, con)
`endif
`endif

[sv/bel_pkg.sv]
// constants and opcodes of the bfs edge labeler
package bel_pkg;
    localparam int MAX_NODES_DEF = 1024;
    localparam int OP_W          = 2;
    localparam int NODE_W        = 11;
    localparam int DEG_W         = 11;
    localparam int LABEL_W       = 10;
    localparam int IDX_W         = 10;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(2);
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
endpackage

[sv/bel_ram.sv]
// generic single-write single-read ram with registered read data
module bel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[sv/bfs_edge_labeler.sv]
// top level of the bfs edge labeler
// Commands are taken while busy is low. Results cannot be stalled: a read command
// puts its label on edge_label with done high for one cycle, after the states
// S_RD_ISS and S_RD_OUT. After reset, at the first load of each load phase and at
// each run, the block sweeps its node memories, one entry a cycle, over all
// MAX_NODES entries. A load then steps through S_LD_RDA, S_LD_WRA, S_LD_RDB and
// S_LD_WRB, or only S_LD_RDA once the edge memory is full. A run then reads and
// compares the degree of each node to find the root, starts the walk, and for each
// node taken from the queue reads and checks every stored edge, with an update step
// for each edge to a neighbor in range; the walk ends when the queue is empty.
module bfs_edge_labeler
    import bel_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [NODE_W-1:0]  node_a,
    input  logic [NODE_W-1:0]  node_b,
    input  logic [IDX_W-1:0]   edge_index,
    input  logic               cfg_we,
    input  logic [NODE_W-1:0]  cfg_wdata,
    output logic               done,
    output logic [LABEL_W-1:0] edge_label
);
`include "assert_macros.svh"

    localparam int ECAP = MAX_NODES - 1;
    localparam int EAW  = (ECAP > 1) ? $clog2(ECAP) : 1;
    localparam int NAW  = $clog2(MAX_NODES);
    localparam int NIW  = $clog2(MAX_NODES + 1);
    localparam int CW   = (NIW > NODE_W) ? NIW : NODE_W;
    localparam int QW   = NAW + 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LD_RDA, S_LD_WRA, S_LD_RDB, S_LD_WRB,
        S_RT_RD, S_RT_CMP, S_WK_INIT, S_WK_POP, S_WK_CUR,
        S_SC_RD, S_SC_CHK, S_SC_UPD, S_RD_ISS, S_RD_OUT
    } state_t;

    typedef enum logic [1:0] {CM_BOOT, CM_LOAD, CM_WALK} clr_mode_t;

    state_t             state_reg;
    clr_mode_t          cmode_reg;
    logic [NAW-1:0]     clr_cnt_reg;
    logic [NODE_W-1:0]  node_count_reg;
    logic               in_load_reg;
    logic [NODE_W-1:0]  a_reg;
    logic [NODE_W-1:0]  b_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [NAW-1:0]     edges_reg;
    logic [LABEL_W-1:0] label_cnt_reg;
    logic [NIW-1:0]     v_reg;
    logic [DEG_W-1:0]   best_reg;
    logic [NIW-1:0]     root_reg;
    logic [QW-1:0]      head_reg;
    logic [QW-1:0]      tail_reg;
    logic [NIW-1:0]     cur_reg;
    logic [NAW-1:0]     e_reg;
    logic [CW-1:0]      nb_reg;
    logic               done_reg;
    logic [LABEL_W-1:0] edge_label_reg;

    logic                  edge_we, deg_we, seen_we, label_we, queue_we;
    logic [EAW-1:0]        edge_waddr, edge_raddr, label_waddr, label_raddr;
    logic [2*NODE_W-1:0]   edge_wdata, edge_rdata;
    logic [NAW-1:0]        deg_waddr, deg_raddr, seen_waddr, seen_raddr;
    logic [NAW-1:0]        queue_waddr, queue_raddr;
    logic [DEG_W-1:0]      deg_wdata, deg_rdata, deg_inc;
    logic                  seen_wdata, seen_rdata;
    logic [LABEL_W-1:0]    label_wdata, label_rdata;
    logic [NIW-1:0]        queue_wdata, queue_rdata;

    logic [CW-1:0] ncount, eff_n, a_cw, b_cw, ea_cw, eb_cw, cur_cw, nb_cw;
    logic [CW-1:0] a_m1, b_m1, nb_m1, nbr_m1, v_m1, root_m1;
    logic          a_ok, b_ok, hit, nb_ok, clr_all, clr_last, unseen, idx_ok;

    assign ncount  = CW'(node_count_reg);
    assign eff_n   = (ncount == '0) ? CW'(1) :
                     (ncount > CW'(MAX_NODES)) ? CW'(MAX_NODES) : ncount;
    assign a_cw    = CW'(a_reg);
    assign b_cw    = CW'(b_reg);
    assign a_ok    = (a_cw != '0) && (a_cw <= CW'(MAX_NODES));
    assign b_ok    = (b_cw != '0) && (b_cw <= CW'(MAX_NODES));
    assign a_m1    = a_cw - CW'(1);
    assign b_m1    = b_cw - CW'(1);
    assign ea_cw   = CW'(edge_rdata[2*NODE_W-1:NODE_W]);
    assign eb_cw   = CW'(edge_rdata[NODE_W-1:0]);
    assign cur_cw  = CW'(cur_reg);
    assign hit     = (ea_cw == cur_cw) || (eb_cw == cur_cw);
    assign nb_cw   = (ea_cw == cur_cw) ? eb_cw : ea_cw;
    assign nb_ok   = hit && (nb_cw != '0) && (nb_cw <= eff_n);
    assign nb_m1   = nb_cw - CW'(1);
    assign nbr_m1  = nb_reg - CW'(1);
    assign v_m1    = CW'(v_reg) - CW'(1);
    assign root_m1 = CW'(root_reg) - CW'(1);
    assign clr_all  = (cmode_reg != CM_WALK);
    assign clr_last = (clr_cnt_reg == NAW'(MAX_NODES - 1));
    assign unseen   = !seen_rdata;
    assign idx_ok   = (32'(idx_reg) < 32'(ECAP));
    assign deg_inc  = (deg_rdata == '1) ? deg_rdata : deg_rdata + DEG_W'(1);

    always_comb
    begin
        edge_we     = (state_reg == S_LD_WRA);
        edge_waddr  = EAW'(edges_reg);
        edge_wdata  = {a_reg, b_reg};
        edge_raddr  = EAW'(e_reg);

        deg_we      = 1'b0;
        deg_waddr   = clr_cnt_reg;
        deg_wdata   = '0;
        deg_raddr   = NAW'(v_m1);
        seen_we     = 1'b0;
        seen_waddr  = clr_cnt_reg;
        seen_wdata  = 1'b0;
        seen_raddr  = NAW'(nb_m1);
        label_we    = 1'b0;
        label_waddr = EAW'(clr_cnt_reg);
        label_wdata = '0;
        label_raddr = EAW'(idx_reg);
        queue_we    = 1'b0;
        queue_waddr = tail_reg[NAW-1:0];
        queue_wdata = NIW'(nb_reg);
        queue_raddr = head_reg[NAW-1:0];

        case (state_reg)
            S_CLR:
            begin
                deg_we   = clr_all;
                seen_we  = 1'b1;
                label_we = clr_all && (32'(clr_cnt_reg) < 32'(ECAP));
            end
            S_LD_RDA: deg_raddr = NAW'(a_m1);
            S_LD_WRA:
            begin
                deg_we    = a_ok;
                deg_waddr = NAW'(a_m1);
                deg_wdata = deg_inc;
            end
            S_LD_RDB: deg_raddr = NAW'(b_m1);
            S_LD_WRB:
            begin
                deg_we    = b_ok;
                deg_waddr = NAW'(b_m1);
                deg_wdata = deg_inc;
            end
            S_WK_INIT:
            begin
                seen_we     = 1'b1;
                seen_waddr  = NAW'(root_m1);
                seen_wdata  = 1'b1;
                queue_we    = 1'b1;
                queue_waddr = '0;
                queue_wdata = root_reg;
            end
            S_SC_UPD:
            begin
                seen_we     = unseen;
                seen_waddr  = NAW'(nbr_m1);
                seen_wdata  = 1'b1;
                label_we    = unseen;
                label_waddr = EAW'(e_reg);
                label_wdata = label_cnt_reg;
                queue_we    = unseen;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cmode_reg      <= CM_BOOT;
            clr_cnt_reg    <= '0;
            node_count_reg <= NODE_COUNT_RST;
            in_load_reg    <= 1'b0;
            edges_reg      <= '0;
            label_cnt_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + NAW'(1);
                    if (clr_last)
                    begin
                        case (cmode_reg)
                            CM_LOAD: state_reg <= S_LD_RDA;
                            CM_WALK:
                            begin
                                state_reg <= S_RT_RD;
                                v_reg     <= NIW'(1);
                                best_reg  <= '0;
                                root_reg  <= NIW'(1);
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_IDLE:
                begin
                    a_reg   <= node_a;
                    b_reg   <= node_b;
                    idx_reg <= edge_index;
                    if (start)
                    begin
                        case (opcode)
                            OP_LOAD:
                            begin
                                in_load_reg <= 1'b1;
                                if (!in_load_reg)
                                begin
                                    state_reg     <= S_CLR;
                                    cmode_reg     <= CM_LOAD;
                                    clr_cnt_reg   <= '0;
                                    edges_reg     <= '0;
                                    label_cnt_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_LD_RDA;
                                end
                            end
                            OP_RUN:
                            begin
                                in_load_reg   <= 1'b0;
                                state_reg     <= S_CLR;
                                cmode_reg     <= CM_WALK;
                                clr_cnt_reg   <= '0;
                                label_cnt_reg <= '0;
                            end
                            OP_READ:
                            begin
                                in_load_reg <= 1'b0;
                                state_reg   <= S_RD_ISS;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LD_RDA: state_reg <= (32'(edges_reg) >= 32'(ECAP)) ? S_IDLE : S_LD_WRA;
                S_LD_WRA: state_reg <= S_LD_RDB;
                S_LD_RDB: state_reg <= S_LD_WRB;
                S_LD_WRB:
                begin
                    edges_reg <= edges_reg + NAW'(1);
                    state_reg <= S_IDLE;
                end
                S_RT_RD: state_reg <= S_RT_CMP;
                S_RT_CMP:
                begin
                    if (deg_rdata > best_reg)
                    begin
                        best_reg <= deg_rdata;
                        root_reg <= v_reg;
                    end
                    if (CW'(v_reg) == eff_n)
                    begin
                        state_reg <= S_WK_INIT;
                    end
                    else
                    begin
                        v_reg     <= v_reg + NIW'(1);
                        state_reg <= S_RT_RD;
                    end
                end
                S_WK_INIT:
                begin
                    head_reg  <= '0;
                    tail_reg  <= QW'(1);
                    state_reg <= S_WK_POP;
                end
                S_WK_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        head_reg  <= head_reg + QW'(1);
                        state_reg <= S_WK_CUR;
                    end
                end
                S_WK_CUR:
                begin
                    cur_reg   <= queue_rdata;
                    e_reg     <= '0;
                    state_reg <= S_SC_RD;
                end
                S_SC_RD: state_reg <= (e_reg == edges_reg) ? S_WK_POP : S_SC_CHK;
                S_SC_CHK:
                begin
                    nb_reg <= nb_cw;
                    if (nb_ok)
                    begin
                        state_reg <= S_SC_UPD;
                    end
                    else
                    begin
                        e_reg     <= e_reg + NAW'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_UPD:
                begin
                    if (unseen)
                    begin
                        label_cnt_reg <= label_cnt_reg + LABEL_W'(1);
                        if (tail_reg < QW'(MAX_NODES))
                        begin
                            tail_reg <= tail_reg + QW'(1);
                        end
                    end
                    e_reg     <= e_reg + NAW'(1);
                    state_reg <= S_SC_RD;
                end
                S_RD_ISS: state_reg <= S_RD_OUT;
                S_RD_OUT:
                begin
                    done_reg       <= 1'b1;
                    edge_label_reg <= idx_ok ? label_rdata : '0;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign edge_label = edge_label_reg;

    bel_ram #(.WIDTH(2*NODE_W), .DEPTH(ECAP)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    bel_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    bel_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen_ram (
        .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(seen_raddr), .rdata(seen_rdata)
    );

    bel_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES)) u_queue_ram (
        .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    bel_ram #(.WIDTH(LABEL_W), .DEPTH(ECAP)) u_label_ram (
        .clk(clk), .we(label_we), .waddr(label_waddr), .wdata(label_wdata),
        .raddr(label_raddr), .rdata(label_rdata)
    );

    `CHK_NXT(a_done_single, clk, rst_n, done, !done)
    `CHK_IMP(a_queue_order, clk, rst_n, 1'b1, head_reg <= tail_reg)
    `CHK_IMP(a_edges_cap, clk, rst_n, 1'b1, 32'(edges_reg) <= 32'(ECAP))
    `CHK_NXT(a_cmd_busy, clk, rst_n, start && !busy && opcode != OP_NONE, busy)
endmodule

[sim/bfs_edge_labeler_tb.sv]
// self-checking testbench for the bfs edge labeler, with an internal label predictor
module bfs_edge_labeler_tb
    import bel_pkg::*;
;

    localparam int NMAX = MAX_NODES_DEF;
    localparam int ECAP = NMAX - 1;
    localparam int STALL_LIMIT = 300000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    opcode;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [IDX_W-1:0]   edge_index;
    logic               cfg_we;
    logic [NODE_W-1:0]  cfg_wdata;
    logic               done;
    logic [LABEL_W-1:0] edge_label;

    // predictor copy of the block state
    logic [NODE_W-1:0]  ends_a [ECAP];
    logic [NODE_W-1:0]  ends_b [ECAP];
    logic [DEG_W-1:0]   degree [NMAX+1];
    bit                 visited [NMAX+1];
    logic [LABEL_W-1:0] labels [ECAP];
    int                 edge_cnt;
    logic [LABEL_W-1:0] label_next;
    bit                 loading;
    logic [NODE_W-1:0]  node_total;

    logic [LABEL_W-1:0] label_q[$];
    int                 err_cnt;
    int                 idle_pct;
    int                 stall_cnt;

    bfs_edge_labeler u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .node_a     (node_a),
        .node_b     (node_b),
        .edge_index (edge_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .edge_label (edge_label)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic void clear_phase();
        for (int i = 0; i <= NMAX; i++)
        begin
            degree[i] = '0;
            visited[i] = 1'b0;
        end
        for (int i = 0; i < ECAP; i++)
            labels[i] = '0;
        edge_cnt = 0;
        label_next = '0;
    endfunction

    function automatic void add_degree(input int v);
        if (v >= 1 && v <= NMAX && degree[v] < 2047)
            degree[v]++;
    endfunction

    function automatic void walk_tree();
        int n, root, head, tail, cur, nb;
        int wq[NMAX];
        logic [DEG_W-1:0] best;
        n = node_total;
        if (n < 1)
            n = 1;
        if (n > NMAX)
            n = NMAX;
        root = 1;
        best = degree[1];
        for (int v = 2; v <= n; v++)
        begin
            if (degree[v] > best)
            begin
                best = degree[v];
                root = v;
            end
        end
        for (int i = 0; i <= NMAX; i++)
            visited[i] = 1'b0;
        label_next = '0;
        visited[root] = 1'b1;
        head = 0;
        tail = 0;
        wq[tail++] = root;
        while (head < tail)
        begin
            cur = wq[head++];
            for (int e = 0; e < edge_cnt; e++)
            begin
                if (ends_a[e] == cur)
                    nb = ends_b[e];
                else if (ends_b[e] == cur)
                    nb = ends_a[e];
                else
                    continue;
                if (nb < 1 || nb > n || visited[nb])
                    continue;
                visited[nb] = 1'b1;
                labels[e] = label_next;
                label_next = label_next + 1'b1;
                if (tail < NMAX)
                    wq[tail++] = nb;
            end
        end
    endfunction

    function automatic void predict_command(input logic [OP_W-1:0] op,
                                            input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            input logic [IDX_W-1:0] idx);
        logic [LABEL_W-1:0] want;
        if (op == OP_LOAD)
        begin
            if (!loading)
            begin
                clear_phase();
                loading = 1'b1;
            end
            if (edge_cnt < ECAP)
            begin
                ends_a[edge_cnt] = a;
                ends_b[edge_cnt] = b;
                edge_cnt++;
                add_degree(a);
                add_degree(b);
            end
        end
        else if (op == OP_RUN)
        begin
            loading = 1'b0;
            walk_tree();
        end
        else if (op == OP_READ)
        begin
            loading = 1'b0;
            want = (idx < ECAP) ? labels[idx] : LABEL_W'(0);
            label_q = {label_q, want};
        end
    endfunction

    // one transaction: optional gap, then hold start until accepted
    task automatic send(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] a,
                        input logic [NODE_W-1:0] b, input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        node_a     <= a;
        node_b     <= b;
        edge_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_command(op, a, b, idx);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (label_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_nodes(input int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= NODE_W'(n);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_total = NODE_W'(n);
        @(posedge clk);
    endtask

    task automatic load(input int a, input int b);
        send(OP_LOAD, NODE_W'(a), NODE_W'(b), '0);
    endtask

    task automatic read_edges(input int cnt);
        for (int i = 0; i < cnt; i++)
            send(OP_READ, NODE_W'($urandom), NODE_W'($urandom), IDX_W'(i));
    endtask

    task automatic test_small_tree();
        set_nodes(5);
        load(1, 2);
        load(1, 3);
        load(2, 4);
        load(2, 5);
        send(OP_RUN, '0, '0, '0);
        read_edges(4);
        send(OP_READ, '0, '0, 10'd1023);
        send(OP_READ, '0, '0, 10'd1022);
    endtask

    task automatic test_odd_edges();
        set_nodes(4);
        load(2, 2);
        load(1, 2);
        send(OP_NONE, 11'h7ff, 11'h7ff, 10'h3ff);
        load(2, 1);
        load(3, 0);
        load(4, 2047);
        load(2, 3);
        load(4, 1);
        send(OP_RUN, '0, '0, '0);
        read_edges(7);
        send(OP_RUN, '0, '0, '0);
        send(OP_READ, '0, '0, IDX_W'(2));
        load(1, 3);
        read_edges(2);
        set_nodes(0);
        load(2, 1);
        load(2, 3);
        send(OP_RUN, '0, '0, '0);
        read_edges(2);
        set_nodes(2047);
        send(OP_RUN, '0, '0, '0);
        read_edges(2);
    endtask

    task automatic test_wide_ids();
        set_nodes(1024);
        load(1024, 1);
        load(1024, 1000);
        load(1000, 7);
        load(1025, 1024);
        send(OP_RUN, '0, '0, '0);
        read_edges(4);
    endtask

    task automatic test_random_trees();
        int n, j, a, b, t;
        int perm[16];
        for (int r = 0; r < 12; r++)
        begin
            idle_pct = r < 4 ? 23 : (r < 8 ? 76 : 0);
            n = $urandom_range(2, 14);
            case ($urandom_range(0, 5))
                0: set_nodes($urandom_range(0, 2047));
                1: set_nodes(n - 1);
                default: set_nodes(n);
            endcase
            for (int i = 0; i < n; i++)
                perm[i] = i + 1;
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int i = 1; i < n; i++)
            begin
                a = perm[i];
                b = perm[$urandom_range(0, i - 1)];
                if ($urandom_range(0, 1))
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                case ($urandom_range(0, 11))
                    0: load($urandom_range(0, 2047), $urandom_range(0, 2047));
                    1: send(OP_NONE, NODE_W'($urandom), NODE_W'($urandom),
                            IDX_W'($urandom));
                    default: ;
                endcase
                load(a, b);
            end
            if ($urandom_range(0, 5) == 0)
                send(OP_READ, '0, '0, IDX_W'($urandom_range(0, 1023)));
            send(OP_RUN, NODE_W'($urandom), NODE_W'($urandom), IDX_W'($urandom));
            read_edges(n);
            send(OP_READ, '0, '0, IDX_W'($urandom_range(0, 1023)));
        end
        idle_pct = 0;
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (label_q.size() == 0)
                report($sformatf("unexpected label %0d", edge_label));
            else if (edge_label !== label_q[0])
            begin
                report($sformatf("edge_label %0d, want %0d", edge_label, label_q[0]));
                void'(label_q.pop_front());
            end
            else
                void'(label_q.pop_front());
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("bfs_edge_labeler_tb: errors");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = '0;
        node_a     = '0;
        node_b     = '0;
        edge_index = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        err_cnt    = 0;
        stall_cnt  = 0;
        idle_pct   = 23;
        node_total = NODE_COUNT_RST;
        loading    = 1'b0;
        clear_phase();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_tree();
        test_odd_edges();
        test_wide_ids();
        idle_pct = 0;
        test_random_trees();
        drain();
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && label_q.size() == 0)
            $display("bfs_edge_labeler_tb: clean");
        else
            $display("bfs_edge_labeler_tb: errors");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/bel_pkg.sv
sv/bel_ram.sv
sv/bfs_edge_labeler.sv
sim/bfs_edge_labeler_tb.sv
